// ===== hw/rtl/point_cloud_idw_gridder_defines.svh =====
// assertion macros for the point cloud idw gridder
`ifndef POINT_CLOUD_IDW_GRIDDER_DEFINES_SVH
`define POINT_CLOUD_IDW_GRIDDER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PCIG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PCIG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/pcig_pkg.sv =====
// shared types, constants and register codes of the point cloud idw gridder
package pcig_pkg;

   localparam int DEF_GRID_COLS = 64;
   localparam int DEF_GRID_ROWS = 64;

   // configuration register indexes
   localparam logic [2:0] CSR_CELL_SIZE_X    = 3'd0;
   localparam logic [2:0] CSR_CELL_SIZE_Y    = 3'd1;
   localparam logic [2:0] CSR_RADIUS_SQUARED = 3'd2;
   localparam logic [2:0] CSR_COLS_IN_USE    = 3'd3;
   localparam logic [2:0] CSR_ROWS_IN_USE    = 3'd4;

   // operation codes
   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READ       = 1'b1;

   localparam logic [31:0] RST_CELL_SIZE  = 32'h0001_0000;
   localparam logic [62:0] RST_RADIUS_SQ  = 63'h1_0000_0000;
   localparam logic [6:0]  RST_GRID_USE   = 7'd64;

   localparam logic [47:0] MAX48      = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] MAX32      = 32'hFFFF_FFFF;
   localparam logic [15:0] COUNT_SAT  = 16'hFFFF;
   localparam logic [63:0] ONE_Q48    = 64'h0001_0000_0000_0000;

   // per cell record in the grid store
   typedef struct packed {
      logic signed [31:0] zmin;
      logic signed [31:0] zmax;
      logic signed [47:0] zsum;
      logic [15:0]        count;
      logic signed [63:0] num;
      logic [47:0]        wsum;
      logic               lock;
   } cell_type;

   localparam cell_type CELL_RESET = '{
      zmin:  32'sh7FFF_FFFF,
      zmax:  32'sh8000_0000,
      zsum:  '0,
      count: '0,
      num:   '0,
      wsum:  '0,
      lock:  1'b0
   };

   // one read result
   typedef struct packed {
      logic               has_data;
      logic [15:0]        point_count;
      logic signed [31:0] z_weighted;
      logic signed [31:0] z_average;
      logic signed [31:0] z_high;
      logic signed [31:0] z_low;
   } result_type;

endpackage

// ===== hw/rtl/point_cloud_idw_gridder.sv =====
// point cloud idw gridder: per cell min, max, mean and inverse distance weighted z
// accumulate: range checks in S_CKX, S_CKY, S_CKY2, then a walk per column and per cell; a cell
//   out of reach, outside the radius, locked or node hit skips the shared divider used for 1/d^2
// read: states S_RA, S_RB, S_RM, S_RI, S_OUT, with up to two passes of the divider (mean, weighted z)
// one item at a time; a read waits in S_OUT while the output register is still full
// reset: synchronous; then a clearing pass over all GRID_COLS*GRID_ROWS cells, no items taken
module point_cloud_idw_gridder #(
   parameter int GRID_COLS = pcig_pkg::DEF_GRID_COLS,
   parameter int GRID_ROWS = pcig_pkg::DEF_GRID_ROWS
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,  // point_x, point_y, point_z, read_col, read_row, zero pad
   input  logic [0:0]   req_tuser,  // op
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,  // z_low, z_high, z_average, z_weighted, point_count,
                                    // has_data, zero pad
   // configuration channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int CELLS = GRID_COLS * GRID_ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(GRID_COLS);
   localparam int RW    = $clog2(GRID_ROWS);
   localparam int ECW   = $clog2(GRID_COLS + 1);
   localparam int ERW   = $clog2(GRID_ROWS + 1);
   localparam int NXW   = 32 + CW;
   localparam int NYW   = 32 + RW;

   // sequencer states
   localparam logic [4:0] S_CLR  = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_CKX  = 5'd2;
   localparam logic [4:0] S_CKY  = 5'd3;
   localparam logic [4:0] S_CKY2 = 5'd4;
   localparam logic [4:0] S_DX   = 5'd5;
   localparam logic [4:0] S_DY   = 5'd6;
   localparam logic [4:0] S_SQY  = 5'd7;
   localparam logic [4:0] S_CMP  = 5'd8;
   localparam logic [4:0] S_UPD  = 5'd9;
   localparam logic [4:0] S_WDIV = 5'd10;
   localparam logic [4:0] S_PROD = 5'd11;
   localparam logic [4:0] S_ACC  = 5'd12;
   localparam logic [4:0] S_WR   = 5'd13;
   localparam logic [4:0] S_NEXT = 5'd14;
   localparam logic [4:0] S_RA   = 5'd15;
   localparam logic [4:0] S_RB   = 5'd16;
   localparam logic [4:0] S_RM   = 5'd17;
   localparam logic [4:0] S_RI   = 5'd18;
   localparam logic [4:0] S_OUT  = 5'd19;

   // configuration registers
   logic [31:0] size_x_ff, size_y_ff;
   logic [62:0] radius_ff;
   logic [6:0]  cols_cfg_ff, rows_cfg_ff;

   // control
   logic [4:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [AW-1:0] base_ff, addr_ff;
   logic          rsp_valid_ff;

   // payload
   logic [31:0]         px_ff, py_ff;
   logic signed [31:0]  z_ff;
   logic [5:0]          rcol_ff, rrow_ff;
   logic [NXW-1:0]      nx_ff;
   logic [NYW-1:0]      ny_ff;
   logic [32:0]         dx_ff;
   logic [31:0]         dy_ff;
   logic [63:0]         a_ff, d2_ff;
   logic [31:0]         w_ff;
   logic signed [67:0]  mul_ff;
   pcig_pkg::cell_type  rec_ff;
   pcig_pkg::cell_type  mem_q_ff;
   pcig_pkg::result_type res_ff;
   pcig_pkg::result_type rsp_ff;

   // grid store
   pcig_pkg::cell_type mem [CELLS];

   // derived configuration
   logic [ECW-1:0] cols_eff;
   logic [ERW-1:0] rows_eff;
   logic [31:0]    sx, sy;

   always_comb begin
      if (cols_cfg_ff == 7'd0) begin
         cols_eff = ECW'(1);
      end else if (32'(cols_cfg_ff) > 32'(GRID_COLS)) begin
         cols_eff = ECW'(GRID_COLS);
      end else begin
         cols_eff = ECW'(cols_cfg_ff);
      end
      if (rows_cfg_ff == 7'd0) begin
         rows_eff = ERW'(1);
      end else if (32'(rows_cfg_ff) > 32'(GRID_ROWS)) begin
         rows_eff = ERW'(GRID_ROWS);
      end else begin
         rows_eff = ERW'(rows_cfg_ff);
      end
      sx = (size_x_ff == 32'd0) ? 32'd1 : size_x_ff;
      sy = (size_y_ff == 32'd0) ? 32'd1 : size_y_ff;
   end

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff   <= pcig_pkg::RST_CELL_SIZE;
         size_y_ff   <= pcig_pkg::RST_CELL_SIZE;
         radius_ff   <= pcig_pkg::RST_RADIUS_SQ;
         cols_cfg_ff <= pcig_pkg::RST_GRID_USE;
         rows_cfg_ff <= pcig_pkg::RST_GRID_USE;
      end else if (csr_valid) begin
         unique case (csr_index)
            pcig_pkg::CSR_CELL_SIZE_X:    size_x_ff   <= csr_data[31:0];
            pcig_pkg::CSR_CELL_SIZE_Y:    size_y_ff   <= csr_data[31:0];
            pcig_pkg::CSR_RADIUS_SQUARED: radius_ff   <= csr_data[62:0];
            pcig_pkg::CSR_COLS_IN_USE:    cols_cfg_ff <= csr_data[6:0];
            pcig_pkg::CSR_ROWS_IN_USE:    rows_cfg_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // shared multiplier operand selection
   logic signed [33:0] mul_a, mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_CKX: begin
            mul_a = 34'(cols_eff) + 34'sd1;
            mul_b = {2'b00, sx};
         end
         S_CKY: begin
            mul_a = 34'(rows_eff) + 34'sd1;
            mul_b = {2'b00, sy};
         end
         S_DY: begin
            mul_a = {1'b0, dx_ff};
            mul_b = {1'b0, dx_ff};
         end
         S_SQY: begin
            mul_a = {2'b00, dy_ff};
            mul_b = {2'b00, dy_ff};
         end
         S_PROD: begin
            mul_a = 34'(z_ff);
            mul_b = {2'b00, w_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   // distance terms
   logic [NXW:0] dx_full;
   logic [NYW:0] dy_full;
   logic         dy_ok;
   logic [64:0]  d2_sum;
   logic         in_radius;

   always_comb begin
      dx_full = ({1'b0, NXW'(px_ff)} >= {1'b0, nx_ff})
              ? {1'b0, NXW'(px_ff)} - {1'b0, nx_ff}
              : {1'b0, nx_ff} - {1'b0, NXW'(px_ff)};
      dy_full = ({1'b0, NYW'(py_ff)} >= {1'b0, ny_ff})
              ? {1'b0, NYW'(py_ff)} - {1'b0, ny_ff}
              : {1'b0, ny_ff} - {1'b0, NYW'(py_ff)};
      dy_ok     = (dy_full >> 32) == '0;
      d2_sum    = {1'b0, a_ff} + {1'b0, mul_ff[63:0]};
      in_radius = !d2_sum[64] && (d2_sum[63:0] <= {1'b0, radius_ff});
   end

   // divider and its operands
   logic        div_start, div_busy, div_done;
   logic [63:0] div_dvd, div_dvs, div_q;
   logic        upd_div;

   assign upd_div = !mem_q_ff.lock && (d2_ff != 64'd0);

   always_comb begin
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      unique case (state_ff)
         S_UPD: begin
            div_start = upd_div;
            div_dvd   = pcig_pkg::ONE_Q48;
            div_dvs   = d2_ff;
         end
         S_RB: begin
            div_start = mem_q_ff.count != 16'd0;
            div_dvd   = mem_q_ff.zsum[47] ? 64'(-mem_q_ff.zsum) : 64'(mem_q_ff.zsum);
            div_dvs   = 64'(mem_q_ff.count);
         end
         S_RM: begin
            div_start = div_done && !rec_ff.lock && (rec_ff.wsum != 48'd0);
            div_dvd   = rec_ff.num[63] ? 64'(-rec_ff.num) : 64'(rec_ff.num);
            div_dvs   = 64'(rec_ff.wsum);
         end
         default: ;
      endcase
   end

   pcig_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   // cell update from the stored record
   pcig_pkg::cell_type upd_rec;
   pcig_pkg::cell_type acc_rec;
   logic signed [64:0] num_sum;
   logic [48:0]        ws_sum;

   always_comb begin
      upd_rec = mem_q_ff;
      if (z_ff < mem_q_ff.zmin) begin
         upd_rec.zmin = z_ff;
      end
      if (z_ff > mem_q_ff.zmax) begin
         upd_rec.zmax = z_ff;
      end
      if (mem_q_ff.count != pcig_pkg::COUNT_SAT) begin
         upd_rec.zsum  = mem_q_ff.zsum + 48'(z_ff);
         upd_rec.count = mem_q_ff.count + 16'd1;
      end
      if (!mem_q_ff.lock && (d2_ff == 64'd0)) begin
         upd_rec.num  = 64'(z_ff);
         upd_rec.lock = 1'b1;
      end
      // saturating weighted accumulation
      acc_rec = rec_ff;
      num_sum = {rec_ff.num[63], rec_ff.num} + {mul_ff[63], mul_ff[63:0]};
      priority if (num_sum[64:63] == 2'b01) begin
         acc_rec.num = 64'sh7FFF_FFFF_FFFF_FFFF;
      end else if (num_sum[64:63] == 2'b10) begin
         acc_rec.num = 64'sh8000_0000_0000_0000;
      end else begin
         acc_rec.num = num_sum[63:0];
      end
      ws_sum = {1'b0, rec_ff.wsum} + 49'(w_ff);
      acc_rec.wsum = ws_sum[48] ? pcig_pkg::MAX48 : ws_sum[47:0];
   end

   // read path helpers
   logic [AW-1:0] rd_addr;
   logic          rd_outside;
   logic [63:0]   mean_q;
   logic [31:0]   idw_val;

   always_comb begin
      rd_outside = (ECW'(rcol_ff) >= cols_eff) || (32'(rcol_ff) >= 32'(GRID_COLS))
                || (ERW'(rrow_ff) >= rows_eff) || (32'(rrow_ff) >= 32'(GRID_ROWS));
      rd_addr    = AW'(32'(rcol_ff) * GRID_ROWS + 32'(rrow_ff));
      mean_q     = rec_ff.zsum[47] ? -div_q : div_q;
      if (rec_ff.num[63]) begin
         idw_val = (div_q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-div_q);
      end else begin
         idw_val = (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
      end
   end

   // memory access
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;

   assign mem_we = (state_ff == S_CLR) || (state_ff == S_WR);
   assign mem_wa = (state_ff == S_CLR) ? clr_ff : addr_ff;
   assign mem_re = ((state_ff == S_CMP) && in_radius) || ((state_ff == S_RA) && !rd_outside);
   assign mem_ra = (state_ff == S_RA) ? rd_addr : addr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= (state_ff == S_CLR) ? pcig_pkg::CELL_RESET : rec_ff;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_ra];
      end
   end

   // sequencer
   logic last_row, last_col;

   assign last_row = (ERW'(row_ff) + ERW'(1)) >= rows_eff;
   assign last_col = (ECW'(col_ff) + ECW'(1)) >= cols_eff;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR:  if (clr_ff == AW'(CELLS - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser[0] == pcig_pkg::OP_READ) ? S_RA : S_CKX;
            end
         end
         S_CKX:  state_in = S_CKY;
         S_CKY:  state_in = ($signed({36'd0, px_ff}) >= mul_ff) ? S_IDLE : S_CKY2;
         S_CKY2: state_in = ($signed({36'd0, py_ff}) >= mul_ff) ? S_IDLE : S_DX;
         S_DX:   state_in = S_DY;
         S_DY:   state_in = (!dx_ff[32] && dy_ok) ? S_SQY : S_NEXT;
         S_SQY:  state_in = S_CMP;
         S_CMP:  state_in = in_radius ? S_UPD : S_NEXT;
         S_UPD:  state_in = upd_div ? S_WDIV : S_WR;
         S_WDIV: if (div_done) state_in = S_PROD;
         S_PROD: state_in = S_ACC;
         S_ACC:  state_in = S_WR;
         S_WR:   state_in = S_NEXT;
         S_NEXT: begin
            priority if (!last_row) begin
               state_in = S_DY;
            end else if (!last_col) begin
               state_in = S_DX;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RA:   state_in = rd_outside ? S_OUT : S_RB;
         S_RB:   state_in = (mem_q_ff.count == 16'd0) ? S_OUT : S_RM;
         S_RM: begin
            if (div_done) begin
               state_in = (!rec_ff.lock && (rec_ff.wsum != 48'd0)) ? S_RI : S_OUT;
            end
         end
         S_RI:   if (div_done) state_in = S_OUT;
         S_OUT:  if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if ((state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // walk counters and datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            px_ff   <= req_tdata[31:0];
            py_ff   <= req_tdata[63:32];
            z_ff    <= req_tdata[95:64];
            rcol_ff <= req_tdata[101:96];
            rrow_ff <= req_tdata[107:102];
            col_ff  <= '0;
            nx_ff   <= '0;
            base_ff <= '0;
         end
         S_DX: begin
            dx_ff   <= (dx_full >> 32) == '0 ? {1'b0, dx_full[31:0]} : {1'b1, 32'd0};
            row_ff  <= '0;
            ny_ff   <= '0;
            addr_ff <= base_ff;
         end
         S_DY:   dy_ff <= dy_full[31:0];
         S_SQY:  a_ff  <= mul_ff[63:0];
         S_CMP:  d2_ff <= d2_sum[63:0];
         S_UPD:  rec_ff <= upd_rec;
         S_WDIV: w_ff <= (div_q > 64'(pcig_pkg::MAX32)) ? pcig_pkg::MAX32 : div_q[31:0];
         S_ACC:  rec_ff <= acc_rec;
         S_NEXT: begin
            if (!last_row) begin
               row_ff  <= row_ff + RW'(1);
               ny_ff   <= ny_ff + NYW'(sy);
               addr_ff <= addr_ff + AW'(1);
            end else begin
               col_ff  <= col_ff + CW'(1);
               nx_ff   <= nx_ff + NXW'(sx);
               base_ff <= base_ff + AW'(GRID_ROWS);
            end
         end
         S_RA:   res_ff <= '0;
         S_RB: begin
            rec_ff <= mem_q_ff;
            if (mem_q_ff.count != 16'd0) begin
               res_ff.z_low       <= mem_q_ff.zmin;
               res_ff.z_high      <= mem_q_ff.zmax;
               res_ff.point_count <= mem_q_ff.count;
               res_ff.has_data    <= 1'b1;
            end
         end
         S_RM: begin
            if (div_done) begin
               res_ff.z_average  <= mean_q[31:0];
               res_ff.z_weighted <= rec_ff.lock ? rec_ff.num[31:0] : 32'sd0;
            end
         end
         S_RI:   if (div_done) res_ff.z_weighted <= idw_val;
         S_OUT:  if (!rsp_valid_ff || rsp_tready) rsp_ff <= res_ff;
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff};

   // checks
   `include "point_cloud_idw_gridder_defines.svh"

   `PCIG_ASSERT_IMP(a_div_idle_start, clock, reset, div_start, !div_busy)
   `PCIG_ASSERT_IMP(a_clear_blocks_req, clock, reset, state_ff == S_CLR, !req_tready)
   `PCIG_ASSERT_NEXT(a_out_loads_rsp, clock, reset,
      (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready), rsp_tvalid)
   `PCIG_ASSERT_IMP(a_write_in_range, clock, reset, mem_we, 32'(mem_wa) < 32'(CELLS))

endmodule

// ===== hw/rtl/pcig_div.sv =====
// radix-2 restoring divider, 64 by 64 bits, one quotient bit per cycle
module pcig_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [63:0] quotient
);

   logic [64:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dvs_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic        fits;

   // one trial subtraction per cycle
   always_comb begin
      trial   = {rem_ff[63:0], quo_ff[63]};
      fits    = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial - {1'b0, dvs_ff} : trial;
         quo_in = {quo_ff[62:0], fits};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== test/tb_point_cloud_idw_gridder.sv =====
// self-checking testbench for the point cloud idw gridder: directed and random points and reads
`timescale 1ns / 100ps

module tb_point_cloud_idw_gridder;

   localparam int          NCOLS      = 64;
   localparam int          NROWS      = 64;
   localparam longint      CYCLE_CAP  = 20_000_000;
   localparam longint unsigned LOW32  = 64'hFFFF_FFFF;
   localparam longint unsigned LOW48  = 64'hFFFF_FFFF_FFFF;
   localparam logic [62:0] RAD_MAX    = 63'h7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic        op;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [5:0]  col;
      logic [5:0]  row;
   } point_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [63:0]  csr_data = '0;

   // shadow of the block's registers
   logic [31:0] size_x_q, size_y_q;
   logic [62:0] radius_sq_q;
   logic [6:0]  cols_q, rows_q;

   // shadow of the grid store
   logic signed [31:0] grid_min [NCOLS*NROWS];
   logic signed [31:0] grid_max [NCOLS*NROWS];
   longint             grid_zsum [NCOLS*NROWS];
   logic [15:0]        grid_count [NCOLS*NROWS];
   logic signed [63:0] grid_num [NCOLS*NROWS];
   longint unsigned    grid_wsum [NCOLS*NROWS];
   logic               grid_lock [NCOLS*NROWS];

   point_item_type        pending_points[$];
   pcig_pkg::result_type  expected_cells[$];
   int             error_count = 0;
   int             accepted_count = 0;
   longint         cycle_count = 0;

   point_cloud_idw_gridder dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic longint unsigned grid_cols();
      if (cols_q < 1) return 1;
      return (cols_q > NCOLS) ? NCOLS : cols_q;
   endfunction

   function automatic longint unsigned grid_rows();
      if (rows_q < 1) return 1;
      return (rows_q > NROWS) ? NROWS : rows_q;
   endfunction

   // fold one point into one cell, d2 in Q32.32
   function automatic void merge_point(int k, logic signed [31:0] z, longint unsigned d2);
      longint unsigned w;
      longint          prod;
      logic [64:0]     total;
      longint unsigned wtot;
      if (z < grid_min[k]) grid_min[k] = z;
      if (z > grid_max[k]) grid_max[k] = z;
      if (grid_count[k] != pcig_pkg::COUNT_SAT) begin
         grid_zsum[k] += longint'(z);
         grid_count[k] += 16'd1;
      end
      if (grid_lock[k]) return;
      // point on the node pins the estimate
      if (d2 == 0) begin
         grid_num[k] = longint'(z);
         grid_lock[k] = 1'b1;
         return;
      end
      w = (64'd1 << 48) / d2;
      if (w > LOW32) w = LOW32;
      prod = longint'(z) * longint'(w);
      total = {grid_num[k][63], grid_num[k]} + {prod[63], prod};
      if (total[64] != total[63])
         grid_num[k] = total[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      else
         grid_num[k] = total[63:0];
      wtot = grid_wsum[k] + w;
      grid_wsum[k] = (wtot > LOW48) ? LOW48 : wtot;
   endfunction

   // spread one point over every node inside the radius
   function automatic void spread_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      longint unsigned sx, sy, cols, rows, xl, yl, node, dx, dy, a, b;
      logic [64:0]     d2;
      sx = (size_x_q == 0) ? 1 : size_x_q;
      sy = (size_y_q == 0) ? 1 : size_y_q;
      cols = grid_cols();
      rows = grid_rows();
      xl = px;
      yl = py;
      if (xl / sx > cols || yl / sy > rows) return;
      for (longint unsigned i = 0; i < cols; i++) begin
         node = i * sx;
         dx = (xl > node) ? xl - node : node - xl;
         for (longint unsigned j = 0; j < rows; j++) begin
            node = j * sy;
            dy = (yl > node) ? yl - node : node - yl;
            if (dx > LOW32 || dy > LOW32) continue;
            a = dx * dx;
            b = dy * dy;
            d2 = {1'b0, a} + {1'b0, b};
            if (d2[64] || d2[63:0] > {1'b0, radius_sq_q}) continue;
            merge_point(int'(i) * NROWS + int'(j), pz, d2[63:0]);
         end
      end
   endfunction

   function automatic logic [31:0] weighted_estimate(int k);
      longint unsigned mag, q;
      logic            neg;
      if (grid_lock[k]) return grid_num[k][31:0];
      if (grid_wsum[k] == 0) return '0;
      neg = grid_num[k][63];
      mag = neg ? 64'd0 - grid_num[k] : grid_num[k];
      q = mag / grid_wsum[k];
      if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
      return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
   endfunction

   function automatic pcig_pkg::result_type summarize_cell(logic [5:0] c, logic [5:0] r);
      pcig_pkg::result_type res;
      int                   k;
      res = '0;
      if (c >= grid_cols() || r >= grid_rows()) return res;
      k = int'(c) * NROWS + int'(r);
      if (grid_count[k] == 0) return res;
      res.z_low       = grid_min[k];
      res.z_high      = grid_max[k];
      res.z_average   = 32'(grid_zsum[k] / longint'({48'd0, grid_count[k]}));
      res.z_weighted  = weighted_estimate(k);
      res.point_count = grid_count[k];
      res.has_data    = 1'b1;
      return res;
   endfunction

   // sender: bursts with random gaps
   int burst_left = 4, gap_left = 0;
   logic req_fire;
   always @(posedge clock) req_fire <= req_tvalid && req_tready;

   always @(negedge clock) begin
      point_item_type it;
      if (!reset && (!req_tvalid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_points.size() > 0) begin
            it = pending_points.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= it.op;
            req_tdata  <= {4'd0, it.row, it.col, it.pz, it.py, it.px};
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: own stall pattern plus one long hold-off
   int  stall_mode = 0, mode_left = 0, hold_left = 0;
   bit  hold_done = 0;
   always @(negedge clock) begin
      if (!hold_done && accepted_count >= 300) begin
         hold_done = 1;
         hold_left = 3000;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 120);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // predict on every accepted request transaction
   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         accepted_count++;
         if (req_tuser[0] == pcig_pkg::OP_READ)
            expected_cells.push_back(summarize_cell(req_tdata[101:96], req_tdata[107:102]));
         else
            spread_point(req_tdata[31:0], req_tdata[63:32], req_tdata[95:64]);
      end
   end

   // compare every result transaction with the oldest expectation
   always @(posedge clock) begin
      pcig_pkg::result_type got, want;
      if (rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[144:0];
         if (expected_cells.size() == 0) begin
            $error("unexpected result transaction %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_cells.pop_front();
            if (got.z_low !== want.z_low) begin
               $error("z_low expected %0d actual %0d", want.z_low, got.z_low);
               error_count++;
            end
            if (got.z_high !== want.z_high) begin
               $error("z_high expected %0d actual %0d", want.z_high, got.z_high);
               error_count++;
            end
            if (got.z_average !== want.z_average) begin
               $error("z_average expected %0d actual %0d", want.z_average, got.z_average);
               error_count++;
            end
            if (got.z_weighted !== want.z_weighted) begin
               $error("z_weighted expected %0d actual %0d", want.z_weighted, got.z_weighted);
               error_count++;
            end
            if (got.point_count !== want.point_count) begin
               $error("point_count expected %0d actual %0d", want.point_count, got.point_count);
               error_count++;
            end
            if (got.has_data !== want.has_data) begin
               $error("has_data expected %0d actual %0d", want.has_data, got.has_data);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("[point_cloud_idw_gridder] ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pcig_pkg::CSR_CELL_SIZE_X:    size_x_q = value[31:0];
         pcig_pkg::CSR_CELL_SIZE_Y:    size_y_q = value[31:0];
         pcig_pkg::CSR_RADIUS_SQUARED: radius_sq_q = value[62:0];
         pcig_pkg::CSR_COLS_IN_USE:    cols_q = value[6:0];
         pcig_pkg::CSR_ROWS_IN_USE:    rows_q = value[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_grid(input logic [31:0] sx, input logic [31:0] sy,
                           input logic [62:0] rad, input logic [6:0] cols,
                           input logic [6:0] rows);
      write_reg(pcig_pkg::CSR_CELL_SIZE_X, {32'd0, sx});
      write_reg(pcig_pkg::CSR_CELL_SIZE_Y, {32'd0, sy});
      write_reg(pcig_pkg::CSR_RADIUS_SQUARED, {1'b0, rad});
      write_reg(pcig_pkg::CSR_COLS_IN_USE, {57'd0, cols});
      write_reg(pcig_pkg::CSR_ROWS_IN_USE, {57'd0, rows});
   endtask

   task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      pending_points.push_back('{pcig_pkg::OP_ACCUMULATE, x, y, z, 6'd0, 6'd0});
   endtask

   task automatic add_read(input logic [5:0] c, input logic [5:0] r);
      pending_points.push_back('{pcig_pkg::OP_READ, $urandom, $urandom, $urandom, c, r});
   endtask

   // a closing read marks the end of all earlier work, the block takes one item at a time
   task automatic drain();
      add_read(6'd0, 6'd0);
      do @(posedge clock);
      while (pending_points.size() != 0 || req_tvalid || expected_cells.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      longint unsigned sx, sy, cols, rows, smin;
      int              pick;
      size_x_q = pcig_pkg::RST_CELL_SIZE;
      size_y_q = pcig_pkg::RST_CELL_SIZE;
      radius_sq_q = pcig_pkg::RST_RADIUS_SQ;
      cols_q = pcig_pkg::RST_GRID_USE;
      rows_q = pcig_pkg::RST_GRID_USE;
      for (int k = 0; k < NCOLS * NROWS; k++) begin
         grid_min[k] = 32'sh7FFF_FFFF;
         grid_max[k] = 32'sh8000_0000;
         grid_zsum[k] = 0;
         grid_count[k] = 0;
         grid_num[k] = 0;
         grid_wsum[k] = 0;
         grid_lock[k] = 1'b0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: node hit, neighbor share, empty and corner reads
      add_point(32'h0001_0000, 32'h0001_0000, 32'h0005_0000);
      add_point(32'h0001_8000, 32'h0001_0000, 32'hFFFD_0000);
      add_point(32'h0003_4000, 32'h0002_C000, 32'h0000_1234);
      add_read(6'd1, 6'd1);
      add_read(6'd2, 6'd1);
      add_read(6'd3, 6'd3);
      add_read(6'd63, 6'd63);
      drain();

      // zero spacing, widest radius, clamped grid, z extremes
      set_grid(32'd0, 32'd0, RAD_MAX, 7'd0, 7'd127);
      add_point(32'd0, 32'd5, 32'h7FFF_FFFF);
      add_point(32'd0, 32'd5, 32'h7FFF_FFFF);
      add_point(32'd0, 32'd3, 32'h8000_0000);
      add_point(32'hFFFF_FFFF, 32'd0, 32'h0000_0001);
      add_read(6'd0, 6'd3);
      add_read(6'd0, 6'd63);
      add_read(6'd1, 6'd0);
      drain();

      // widest spacing and zero radius: only exact node hits count
      set_grid(32'hFFFF_FFFF, 32'hFFFF_FFFF, 63'd0, 7'd2, 7'd2);
      add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_point(32'hFFFF_FFFF, 32'd0, 32'd123);
      add_point(32'h8000_0000, 32'd0, 32'd77);
      add_read(6'd1, 6'd1);
      add_read(6'd1, 6'd0);
      drain();

      // far nodes give zero weight; far point is dropped
      set_grid(32'h1000_0000, 32'h1000_0000, RAD_MAX, 7'd2, 7'd2);
      add_point(32'h0800_0000, 32'h0800_0000, 32'h0001_0000);
      add_point(32'hFFFF_FFFF, 32'h0000_0000, 32'h0002_0000);
      add_read(6'd1, 6'd1);
      add_read(6'd5, 6'd5);
      drain();

      // random phases on small grids
      for (int ph = 0; ph < 10; ph++) begin
         cols = $urandom_range(1, 7);
         rows = $urandom_range(1, 7);
         sx = $urandom_range(32'h4000, 32'h30000);
         sy = ($urandom_range(0, 1) == 0) ? sx : $urandom_range(32'h4000, 32'h30000);
         smin = (sx < sy) ? sx : sy;
         set_grid(sx[31:0], sy[31:0], 63'((smin * smin * $urandom_range(0, 8)) / 4),
                  cols[6:0], rows[6:0]);
         for (int n = 0; n < 104; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               if ($urandom_range(0, 1))
                  add_read(6'($urandom_range(0, 32'(cols))), 6'($urandom_range(0, 32'(rows))));
               else
                  add_read(6'($urandom), 6'($urandom));
            end else if (pick < 60) begin
               add_point(32'($urandom_range(0, 32'(cols - 1)) * sx),
                         32'($urandom_range(0, 32'(rows - 1)) * sy),
                         $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 32'h7_0000)));
            end else if (pick < 92) begin
               add_point(32'($urandom_range(0, 32'(cols * sx))),
                         32'($urandom_range(0, 32'(rows * sy))),
                         $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 32'h7_0000)));
            end else begin
               pending_points.push_back('{1'($urandom), $urandom, $urandom, $urandom,
                                          6'($urandom), 6'($urandom)});
            end
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("[point_cloud_idw_gridder] OK");
      else
         $display("[point_cloud_idw_gridder] ERROR");
      $finish;
   end

endmodule
